/* rtl/lfir_pkg.sv */
// Shared types and constants for the linear convolution FIR block.
package lfir_pkg;

  // Fixed field widths.
  localparam int COEF_BITS      = 16;
  localparam int TAPS_BITS      = 3;
  localparam int CFG_IDX_BITS   = 3;
  localparam int OUT_BITS       = 34;
  localparam int OUT_TDATA_BITS = 40;

  // Register index of the tap count; indexes below it select coefficients.
  localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_COUNT = 3'd7;

  // Running sum handed from one cell to the next.
  typedef struct packed {
    logic                       last;
    logic signed [OUT_BITS-1:0] acc;
  } lfir_sum_t;

  // Input sequencer state: streaming samples or flushing the tail.
  typedef enum logic {
    FEED_STREAM,
    FEED_FLUSH
  } lfir_feed_state_t;

endpackage

/* rtl/linear_convolution_fir.sv */
// Top level of the streaming linear convolution FIR filter (direct form, chain of tap cells).
// Pipeline: MAX_TAPS register stages, one per tap cell; the last cell drives the master side.
// Throughput: one sample per cycle while the master side accepts; a sample marked last holds
// the slave side off while the tail words are pushed into the chain.
// Reset: coefficients clear, tap_count goes to one, the delay line clears, the chain empties.
module linear_convolution_fir
  import lfir_pkg::*;
#(
  parameter int MAX_TAPS    = 7,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Sample stream. s_tdata: sample_value (SAMPLE_BITS, signed), zero padded to bytes.
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,
  input  logic                                  s_tlast,
  // Result stream. m_tdata: conv_value (34 bits, signed), zero padded to 40 bits.
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [OUT_TDATA_BITS-1:0]             m_tdata,
  output logic                                  m_tlast,
  // Register writes: indexes 0 to 6 are coefficients, index 7 is tap_count.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]               cfg_index,
  input  logic [COEF_BITS-1:0]                  cfg_data
);

  // Coefficients for taps the chain does not have are never read, so only
  // MAX_TAPS of them are kept; writes to the others fall away.
  logic signed [COEF_BITS-1:0] coef [MAX_TAPS];
  logic [TAPS_BITS-1:0]        tap_count;
  logic [TAPS_BITS-1:0]        taps;
  logic [MAX_TAPS-1:0]         active;

  // Chain plumbing: position 0 is the sequencer output, position k+1 is cell k.
  logic [MAX_TAPS:0]             stage_valid;
  logic [MAX_TAPS:0]             stage_ready;
  logic signed [SAMPLE_BITS-1:0] stage_win [MAX_TAPS+1][MAX_TAPS];
  lfir_sum_t                     stage_sum [MAX_TAPS+1];
  logic                          launch_last;

  // The register port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_TAPS; k++) begin
        coef[k] <= '0;
      end
      tap_count <= 3'd1;
    end else if (cfg_valid) begin
      for (int k = 0; k < MAX_TAPS; k++) begin
        if (cfg_index == CFG_IDX_BITS'(k)) begin
          coef[k] <= signed'(cfg_data);
        end
      end
      if (cfg_index == CFG_TAP_COUNT) begin
        tap_count <= cfg_data[TAPS_BITS-1:0];
      end
    end
  end

  // A tap count of zero acts as one tap, and a count beyond the chain length
  // saturates at the chain length.
  always_comb begin
    taps = tap_count;
    if (tap_count == 3'd0) begin
      taps = 3'd1;
    end else if (int'(tap_count) > MAX_TAPS) begin
      taps = TAPS_BITS'(MAX_TAPS);
    end
    for (int k = 0; k < MAX_TAPS; k++) begin
      active[k] = TAPS_BITS'(k) < taps;
    end
  end

  // The sequencer hands each cell chain word the full window: the new sample
  // (or zero while flushing the tail) followed by the delay line.
  lfir_feed #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_TAPS    (MAX_TAPS)
  ) u_feed (
    .clk          (clk),
    .rst          (rst),
    .taps         (taps),
    .s_valid      (s_tvalid),
    .s_ready      (s_tready),
    .sample       (signed'(s_tdata[SAMPLE_BITS-1:0])),
    .final_in     (s_tlast),
    .launch_valid (stage_valid[0]),
    .launch_ready (stage_ready[0]),
    .launch_win   (stage_win[0]),
    .launch_last  (launch_last)
  );

  assign stage_sum[0].acc  = '0;
  assign stage_sum[0].last = launch_last;

  // Each cell adds its own tap's product as the word passes. Every cell
  // holds a word until the next one can take it, so bubbles close up and the
  // chain keeps accepting while the output register is stalled, until all cells are full.
  generate
    for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
      lfir_cell #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_TAPS    (MAX_TAPS),
        .TAP         (k)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .coef      (coef[k]),
        .active    (active[k]),
        .in_valid  (stage_valid[k]),
        .in_ready  (stage_ready[k]),
        .in_win    (stage_win[k]),
        .in_sum    (stage_sum[k]),
        .out_valid (stage_valid[k+1]),
        .out_ready (stage_ready[k+1]),
        .out_win   (stage_win[k+1]),
        .out_sum   (stage_sum[k+1])
      );
    end
  endgenerate

  // The last cell's register is the output register.
  assign m_tvalid              = stage_valid[MAX_TAPS];
  assign stage_ready[MAX_TAPS] = m_tready;
  assign m_tdata = {{(OUT_TDATA_BITS-OUT_BITS){1'b0}}, stage_sum[MAX_TAPS].acc};
  assign m_tlast = stage_sum[MAX_TAPS].last;

endmodule

/* rtl/lfir_cell.sv */
// One tap cell: multiplies its coefficient by its window sample and adds to the running sum.
module lfir_cell
  import lfir_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_TAPS    = 7,
  parameter int TAP         = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic signed [COEF_BITS-1:0]   coef,
  input  logic                          active,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_win [MAX_TAPS],
  input  lfir_sum_t                     in_sum,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_win [MAX_TAPS],
  output lfir_sum_t                     out_sum
);

  localparam int PROD_BITS = COEF_BITS + SAMPLE_BITS;

  logic signed [PROD_BITS-1:0] prod;
  logic signed [OUT_BITS-1:0]  term;

  // The stage takes a new word when it is empty or its word moves on.
  assign in_ready = !out_valid || out_ready;

  always_comb begin
    prod = coef * in_win[TAP];
    term = active ? OUT_BITS'(prod) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_win      <= in_win;
      out_sum.acc  <= in_sum.acc + term;
      out_sum.last <= in_sum.last;
    end
  end

endmodule

/* rtl/lfir_feed.sv */
// Input sequencer: keeps the delay line, builds each sample window and flushes the tail.
module lfir_feed
  import lfir_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_TAPS    = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [TAPS_BITS-1:0]          taps,
  input  logic                          s_valid,
  output logic                          s_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          final_in,
  output logic                          launch_valid,
  input  logic                          launch_ready,
  output logic signed [SAMPLE_BITS-1:0] launch_win [MAX_TAPS],
  output logic                          launch_last
);

  lfir_feed_state_t            state, state_next;
  logic [TAPS_BITS-1:0]        remain, remain_next;
  logic signed [SAMPLE_BITS-1:0] head;
  logic                        fire;
  logic                        do_shift;
  logic                        do_clear;

  // During the flush the window is fed zeros in place of a new sample.
  assign head         = (state == FEED_FLUSH) ? '0 : sample;
  assign launch_valid = (state == FEED_FLUSH) || s_valid;
  assign s_ready      = (state == FEED_STREAM) && launch_ready;
  assign fire         = launch_valid && launch_ready;

  always_comb begin
    state_next  = state;
    remain_next = remain;
    launch_last = 1'b0;
    do_shift    = 1'b0;
    do_clear    = 1'b0;
    unique case (state)
      FEED_STREAM: begin
        if (fire) begin
          if (final_in && (taps > 3'd1)) begin
            state_next  = FEED_FLUSH;
            remain_next = taps - 3'd1;
            do_shift    = 1'b1;
          end else if (final_in) begin
            launch_last = 1'b1;
            do_clear    = 1'b1;
          end else begin
            do_shift = 1'b1;
          end
        end
      end
      FEED_FLUSH: begin
        if (fire) begin
          if (remain == 3'd1) begin
            launch_last = 1'b1;
            do_clear    = 1'b1;
            state_next  = FEED_STREAM;
          end else begin
            remain_next = remain - 3'd1;
            do_shift    = 1'b1;
          end
        end
      end
      default: begin
        state_next = FEED_STREAM;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= FEED_STREAM;
      remain <= '0;
    end else begin
      state  <= state_next;
      remain <= remain_next;
    end
  end

  assign launch_win[0] = head;

  generate
    if (MAX_TAPS > 1) begin : g_dline
      logic signed [SAMPLE_BITS-1:0] dline [MAX_TAPS-1];

      for (genvar k = 1; k < MAX_TAPS; k++) begin : g_win
        assign launch_win[k] = dline[k-1];
      end

      // Newest sample first; the whole line is cleared after a sequence ends.
      always_ff @(posedge clk) begin
        if (rst || do_clear) begin
          for (int k = 0; k < MAX_TAPS - 1; k++) begin
            dline[k] <= '0;
          end
        end else if (do_shift) begin
          dline[0] <= head;
          for (int k = 1; k < MAX_TAPS - 1; k++) begin
            dline[k] <= dline[k-1];
          end
        end
      end
    end
  endgenerate

endmodule

/* sim/testbench.sv */
// Self-checking stream testbench for the linear convolution FIR filter.
`timescale 1ns / 1ps

module testbench;
  import lfir_pkg::*;

  localparam int MAX_TAPS    = 7;
  localparam int SAMPLE_BITS = 16;
  localparam int NUM_COEFS   = 7;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_WAIT  = MAX_TAPS + 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_GOAL = 260;

  // One expected output word: the convolution value and the end-of-sequence mark.
  typedef struct packed {
    logic signed [OUT_BITS-1:0] value;
    logic                       last;
  } conv_word_t;

  // The directed table mixes two kinds of rows. A setting row loads the even
  // coefficients with value, the odd ones with odd_coef and the tap count
  // register with taps_word. A sample row sends value, marked final by fin;
  // where typed is set, want is the first output that the sample must cause.
  typedef enum logic {
    ROW_SETTING,
    ROW_SAMPLE
  } row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    logic signed [15:0]         value;
    logic signed [15:0]         odd_coef;
    logic [15:0]                taps_word;
    logic                       fin;
    logic                       typed;
    logic signed [OUT_BITS-1:0] want;
  } step_row_t;

  logic                        clk;
  logic                        rst;
  logic                        s_tvalid;
  logic                        s_tready;
  logic [SAMPLE_BITS-1:0]      s_tdata;   // [15:0] sample_value
  logic                        s_tlast;   // final_sample
  logic                        m_tvalid;
  logic                        m_tready;
  logic [OUT_TDATA_BITS-1:0]   m_tdata;   // [33:0] conv_value, [39:34] zero
  logic                        m_tlast;   // final_output
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CFG_IDX_BITS-1:0]     cfg_index;
  logic [COEF_BITS-1:0]        cfg_data;

  // The predictor's own copy of the registers and of the delay line (newest first).
  logic signed [COEF_BITS-1:0]   kernel [NUM_COEFS];
  logic [TAPS_BITS-1:0]          tap_setting;
  logic signed [SAMPLE_BITS-1:0] history [MAX_TAPS-1];

  // Output words predicted but not yet seen on the master side, oldest first.
  conv_word_t conv_expect[$];

  int  error_count;
  int  cycle_count;
  int  samples_in;
  int  words_out;
  int  sequence_ends;
  int  settings_loaded;
  bit  quiet_run;      // no idling on either side while set
  bit  hold_request;   // asks the receiver for one long hold-off

  step_row_t directed_rows [22] = '{
    // Straight out of reset all coefficients are zero and one tap is active,
    // so every output is zero; a final sample with one tap gives one word.
    '{ROW_SAMPLE,  16'sh7FFF, 16'sh0000, 16'h0000, 1'b0, 1'b1, 34'sd0},
    '{ROW_SAMPLE,  16'sh8000, 16'sh0000, 16'h0000, 1'b1, 1'b1, 34'sd0},
    // Full kernel of most negative coefficients times most negative samples:
    // the sum grows to seven times 2**30, the largest the output ever holds.
    '{ROW_SETTING, 16'sh8000, 16'sh8000, 16'h0007, 1'b0, 1'b0, 34'sd0},
    '{ROW_SAMPLE,  16'sh8000, 16'sh0000, 16'h0000, 1'b0, 1'b1, 34'sd1073741824},
    '{ROW_SAMPLE,  16'sh8000, 16'sh0000, 16'h0000, 1'b0, 1'b0, 34'sd0},
    '{ROW_SAMPLE,  16'sh8000, 16'sh0000, 16'h0000, 1'b0, 1'b0, 34'sd0},
    '{ROW_SAMPLE,  16'sh8000, 16'sh0000, 16'h0000, 1'b0, 1'b0, 34'sd0},
    '{ROW_SAMPLE,  16'sh8000, 16'sh0000, 16'h0000, 1'b0, 1'b0, 34'sd0},
    '{ROW_SAMPLE,  16'sh8000, 16'sh0000, 16'h0000, 1'b0, 1'b0, 34'sd0},
    '{ROW_SAMPLE,  16'sh8000, 16'sh0000, 16'h0000, 1'b0, 1'b1, 34'sd7516192768},
    '{ROW_SAMPLE,  16'sh8000, 16'sh0000, 16'h0000, 1'b1, 1'b1, 34'sd7516192768},
    // A tap count of zero behaves as one tap; the upper data bits are junk.
    '{ROW_SETTING, 16'sh7FFF, 16'sh8000, 16'hFFF8, 1'b0, 1'b0, 34'sd0},
    '{ROW_SAMPLE,  16'sh7FFF, 16'sh0000, 16'h0000, 1'b0, 1'b1, 34'sd1073676289},
    '{ROW_SAMPLE,  16'sh8000, 16'sh0000, 16'h0000, 1'b0, 1'b1, -34'sd1073709056},
    '{ROW_SAMPLE,  16'sh0001, 16'sh0000, 16'h0000, 1'b0, 1'b0, 34'sd0},
    // The tap count changes while the delay line still holds the samples above.
    '{ROW_SETTING, 16'sh7FFF, 16'sh7FFF, 16'h0004, 1'b0, 1'b0, 34'sd0},
    '{ROW_SAMPLE,  16'sh0000, 16'sh0000, 16'h0000, 1'b0, 1'b0, 34'sd0},
    '{ROW_SAMPLE,  16'sh3039, 16'sh0000, 16'h0000, 1'b1, 1'b0, 34'sd0},
    // Alternating unit coefficients over three taps with checkerboard samples.
    '{ROW_SETTING, 16'sh0001, 16'shFFFF, 16'hABC3, 1'b0, 1'b0, 34'sd0},
    '{ROW_SAMPLE,  16'sh5555, 16'sh0000, 16'h0000, 1'b0, 1'b0, 34'sd0},
    '{ROW_SAMPLE,  16'shAAAA, 16'sh0000, 16'h0000, 1'b0, 1'b0, 34'sd0},
    '{ROW_SAMPLE,  16'sh0000, 16'sh0000, 16'h0000, 1'b1, 1'b0, 34'sd0}
  };

  linear_convolution_fir #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 4 ns clock: two ns high, two ns low.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Counts one mismatch; only the first ten are printed in full.
  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("MISMATCH: %s", msg);
    end
  endtask

  // Mirrors one register write into the predictor's copy. Only the low three
  // bits of the data reach the tap count.
  task automatic mirror_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] data);
    if (idx == CFG_TAP_COUNT) begin
      tap_setting = data[TAPS_BITS-1:0];
    end else begin
      kernel[idx] = data;
    end
  endtask

  // Predicts the words caused by one accepted sample and queues them. A
  // sample marked final is followed, when more than one tap is active, by tail
  // steps that shift in zeros; the last word carries the end mark and the delay
  // line is cleared. Returns how many words were queued.
  function automatic int convolve_sample(input logic signed [15:0] x, input logic fin);
    int                 taps;
    int                 steps;
    longint             acc;
    logic signed [15:0] cur;
    conv_word_t         w;
    taps  = (tap_setting == '0) ? 1 : int'(tap_setting);
    steps = fin ? taps : 1;
    for (int t = 0; t < steps; t++) begin
      cur = (t == 0) ? x : 16'sh0000;
      acc = longint'(kernel[0]) * longint'(cur);
      for (int k = 1; k < taps; k++) begin
        acc += longint'(kernel[k]) * longint'(history[k-1]);
      end
      for (int k = MAX_TAPS - 2; k > 0; k--) begin
        history[k] = history[k-1];
      end
      history[0] = cur;
      w.value = acc[OUT_BITS-1:0];
      w.last  = fin && (t == steps - 1);
      conv_expect.insert(conv_expect.size(), w);
    end
    if (fin) begin
      foreach (history[k]) history[k] = '0;
    end
    return steps;
  endfunction

  // Writes the whole register set: seven coefficients, then the tap count.
  task automatic load_setting(input logic signed [15:0] coefs [NUM_COEFS],
                              input logic [15:0] taps_word);
    for (int i = 0; i <= NUM_COEFS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[CFG_IDX_BITS-1:0];
      cfg_data  <= (i == NUM_COEFS) ? taps_word : coefs[i];
      do begin
        @(posedge clk);
      end while (!(cfg_valid && cfg_ready));
      mirror_write(i[CFG_IDX_BITS-1:0], (i == NUM_COEFS) ? taps_word : coefs[i]);
    end
    cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  // Offers one sample word, with random idle cycles in front of it unless a
  // quiet stretch is running, and predicts its outputs once it is accepted.
  task automatic push_sample(input logic signed [15:0] v, input logic fin,
                             input logic typed, input logic signed [OUT_BITS-1:0] want);
    int         n;
    int         slot;
    conv_word_t w;
    while (!quiet_run && $urandom_range(99) < 11) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= fin;
    do begin
      @(posedge clk);
    end while (!(s_tvalid && s_tready));
    n = convolve_sample(v, fin);
    samples_in++;
    if (typed) begin
      // The first output of this sample is known by inspection; it stands in
      // for the prediction.
      slot    = conv_expect.size() - n;
      w       = conv_expect[slot];
      w.value = want;
      conv_expect[slot] = w;
    end
  endtask

  // Stops offering samples, waits for every expected word, then lets the
  // pipeline settle before anything touches the registers.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (conv_expect.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return r[3:0] - 16'sd8;
      default: return r[15:0];
    endcase
  endfunction

  function automatic logic signed [15:0] rand_coef();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return r[2:0] - 16'sd4;
      default: return r[15:0];
    endcase
  endfunction

  // Receiver: accepts with random stalls, except in a quiet stretch. When the
  // stimulus asks for it, it holds off for a long stretch so that the filter
  // fills up and has to push back on its sample input.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) begin
          m_tready <= 1'b0;
          @(posedge clk);
        end
      end
      m_tready <= quiet_run || ($urandom_range(99) >= 11);
    end
  end

  // Output checker: every accepted word is compared with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      words_out++;
      if (conv_expect.size() == 0) begin
        flag_error($sformatf("unexpected word value=%0d last=%0b",
                             $signed(m_tdata[OUT_BITS-1:0]), m_tlast));
      end else begin
        if (conv_expect[0].last) begin
          sequence_ends++;
        end
        // The padding above the value must stay zero, so the whole word is compared.
        if (m_tdata !== {{(OUT_TDATA_BITS-OUT_BITS){1'b0}}, conv_expect[0].value}) begin
          flag_error($sformatf("word %0d value: expected %0d, got %0d (tdata %h)",
                               words_out, conv_expect[0].value,
                               $signed(m_tdata[OUT_BITS-1:0]), m_tdata));
        end
        if (m_tlast !== conv_expect[0].last) begin
          flag_error($sformatf("word %0d last: expected %0b, got %0b",
                               words_out, conv_expect[0].last, m_tlast));
        end
        void'(conv_expect.pop_front());
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, conv_expect.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    logic signed [15:0] coefs [NUM_COEFS];
    logic [31:0]        r;
    int                 target;
    int                 sent;
    int                 len;
    bit                 broken;
    bit                 paused;

    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    quiet_run = 1'b0;
    hold_request = 1'b0;
    error_count = 0;
    cycle_count = 0;
    samples_in = 0;
    words_out = 0;
    sequence_ends = 0;
    settings_loaded = 0;
    paused = 1'b0;
    foreach (kernel[k]) kernel[k] = '0;
    foreach (history[k]) history[k] = '0;
    tap_setting = 3'd1;

    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part: walk the table.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_SETTING) begin
        wait_idle();
        foreach (coefs[k]) begin
          coefs[k] = (k % 2 == 0) ? directed_rows[i].value : directed_rows[i].odd_coef;
        end
        load_setting(coefs, directed_rows[i].taps_word);
      end else begin
        push_sample(directed_rows[i].value, directed_rows[i].fin,
                    directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random part, in phases with a fresh kernel each. Most sequences are
    // well formed and end on a final sample; some stop short, so that a later
    // sequence, or the next phase under a new tap count, starts with a loaded delay line.
    for (int phase = 0; samples_in < RANDOM_GOAL; phase++) begin
      wait_idle();
      quiet_run = (phase == 1);
      foreach (coefs[k]) coefs[k] = rand_coef();
      r = $urandom;
      load_setting(coefs, r[15:0]);
      if (phase == 2) begin
        hold_request = 1'b1;
      end
      target = $urandom_range(20, 35);
      sent = 0;
      while (sent < target) begin
        if (phase == 3 && !paused && sent >= target / 2) begin
          // The sender stops until the filter has delivered everything.
          paused = 1'b1;
          s_tvalid <= 1'b0;
          do begin
            @(posedge clk);
          end while (conv_expect.size() != 0);
        end
        len = $urandom_range(1, 10);
        broken = ($urandom_range(99) < 15);
        for (int i = 0; i < len; i++) begin
          push_sample(rand_sample(), !broken && (i == len - 1), 1'b0, '0);
        end
        sent += len;
      end
    end

    quiet_run = 1'b0;
    wait_idle();

    $display("covered %0d samples and %0d output words, %0d complete sequences,",
             samples_in, words_out, sequence_ends);
    $display("under %0d kernel settings with stalls, idling and a long hold-off",
             settings_loaded);
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
